// File: sv/maf_pkg.sv
// Package for the MAC admission filter: word layouts, control and status
// structs between controller and datapath, and the header check constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package maf_pkg;

    localparam int DEFAULT_ALLOW_DEPTH = 16;
    localparam int DEFAULT_DENY_DEPTH  = 16;

    // Command codes of an input word.
    localparam logic [1:0] CMD_PACKET = 2'd0;
    localparam logic [1:0] CMD_ACCEPT = 2'd1;
    localparam logic [1:0] CMD_DENY   = 2'd2;
    localparam logic [1:0] CMD_IGNORE = 2'd3;

    // Outcome codes of a result word.
    localparam logic [3:0] OUT_MALFORMED     = 4'd0;
    localparam logic [3:0] OUT_KNOWN_ALLOWED = 4'd1;
    localparam logic [3:0] OUT_KNOWN_DENIED  = 4'd2;
    localparam logic [3:0] OUT_BUSY          = 4'd3;
    localparam logic [3:0] OUT_NEW_REQUEST   = 4'd4;
    localparam logic [3:0] OUT_NO_PENDING    = 4'd5;
    localparam logic [3:0] OUT_ADDED_ALLOWED = 4'd6;
    localparam logic [3:0] OUT_ADDED_DENIED  = 4'd7;
    localparam logic [3:0] OUT_IGNORED       = 4'd8;
    localparam logic [3:0] OUT_TABLE_FULL    = 4'd9;

    // Header checks.
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [15:0] MAC_BYTES      = 16'd6;
    localparam logic [15:0] MIN_PAYLOAD    = 16'd40;
    localparam logic [3:0]  IP_VERSION     = 4'd4;
    localparam logic [3:0]  IP_IHL         = 4'd5;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [12:0] FRAG_NONE      = 13'h0000;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] packet_tag;
        logic [15:0] link_protocol;
        logic [15:0] mac_length;
        logic [15:0] payload_bytes;
        logic [7:0]  version_and_ihl;
        logic [15:0] fragment_word;
        logic [7:0]  ip_protocol;
        logic        syn_flag;
        logic [47:0] source_mac;
        logic [31:0] source_ip;
        logic [15:0] target_port;
    } in_item_t;

    typedef struct packed {
        logic [31:0] tag_out;
        logic        verdict;
        logic [3:0]  outcome;
        logic [47:0] request_mac;
        logic [31:0] request_ip;
        logic [15:0] request_port;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       take;
        logic       idx_clear;
        logic       idx_inc;
        logic       rd_allow;
        logic       rd_deny;
        logic       wr_allow;
        logic       wr_deny;
        logic       set_pending;
        logic       clear_pending;
        logic       load_out;
        logic [3:0] outcome;
    } ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       in_valid;
        logic [1:0] cmd;
        logic       pkt_ok;
        logic       pending;
        logic       allow_full;
        logic       deny_full;
        logic       allow_end;
        logic       deny_end;
        logic       allow_hit;
        logic       deny_hit;
        logic       out_free;
    } stat_t;

endpackage

`default_nettype wire

// File: sv/maf_stream_if.sv
// Valid/ready channel carrying one word of a given payload type.
// Used by the top level for its input and result channels.
`timescale 1ns / 1ps
`default_nettype none

interface maf_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: sv/mac_admission_filter.sv
// MAC admission filter. A command word or malformed packet gives its result
// from the decode state; a well-formed packet scans the allow table and then
// the deny table, one memory read and one compare per entry, stopping at the first hit.
// The result is loaded once the output register is free, and the next word is
// taken in the cycle after the result is loaded into the output register.
// Reset clears the counts, the pending flag and the output valid; table contents are kept.
`timescale 1ns / 1ps
`default_nettype none

module mac_admission_filter #(
    parameter int ALLOW_DEPTH = maf_pkg::DEFAULT_ALLOW_DEPTH,
    parameter int DENY_DEPTH  = maf_pkg::DEFAULT_DENY_DEPTH
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    maf_stream_if.sink   req,
    maf_stream_if.source rsp
);
    import maf_pkg::*;

    ctrl_t ctl;
    stat_t st;

    maf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .ctl   (ctl)
    );

    maf_datapath #(
        .ALLOW_DEPTH (ALLOW_DEPTH),
        .DENY_DEPTH  (DENY_DEPTH)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .ctl   (ctl),
        .st    (st)
    );

endmodule

`default_nettype wire

// File: sv/maf_ctrl.sv
// Controller of the MAC admission filter: sequences decode, table scans,
// table updates and the result load. Depends on maf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module maf_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire maf_pkg::stat_t st,
    output maf_pkg::ctrl_t      ctl
);
    import maf_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_A_RD   = 3'd2;
    localparam logic [2:0] S_A_CMP  = 3'd3;
    localparam logic [2:0] S_D_RD   = 3'd4;
    localparam logic [2:0] S_D_CMP  = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [3:0] outcome_reg;
    logic [3:0] outcome_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            outcome_reg <= OUT_MALFORMED;
        end
        else
        begin
            state_reg   <= state_next;
            outcome_reg <= outcome_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        outcome_next = outcome_reg;
        ctl          = '0;
        ctl.outcome  = outcome_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                ctl.take = 1'b1;
                if (st.in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_FINISH;
                if (st.cmd == CMD_PACKET)
                begin
                    if (!st.pkt_ok)
                    begin
                        outcome_next = OUT_MALFORMED;
                    end
                    else
                    begin
                        ctl.idx_clear = 1'b1;
                        state_next    = S_A_RD;
                    end
                end
                else if (!st.pending)
                begin
                    outcome_next = OUT_NO_PENDING;
                end
                else
                begin
                    unique case (st.cmd)
                        CMD_ACCEPT:
                        begin
                            if (st.allow_full)
                            begin
                                outcome_next = OUT_TABLE_FULL;
                            end
                            else
                            begin
                                ctl.wr_allow      = 1'b1;
                                ctl.clear_pending = 1'b1;
                                outcome_next      = OUT_ADDED_ALLOWED;
                            end
                        end
                        CMD_DENY:
                        begin
                            if (st.deny_full)
                            begin
                                outcome_next = OUT_TABLE_FULL;
                            end
                            else
                            begin
                                ctl.wr_deny       = 1'b1;
                                ctl.clear_pending = 1'b1;
                                outcome_next      = OUT_ADDED_DENIED;
                            end
                        end
                        default:
                        begin
                            ctl.clear_pending = 1'b1;
                            outcome_next      = OUT_IGNORED;
                        end
                    endcase
                end
            end
            S_A_RD:
            begin
                if (st.allow_end)
                begin
                    ctl.idx_clear = 1'b1;
                    state_next    = S_D_RD;
                end
                else
                begin
                    ctl.rd_allow = 1'b1;
                    state_next   = S_A_CMP;
                end
            end
            S_A_CMP:
            begin
                if (st.allow_hit)
                begin
                    outcome_next = OUT_KNOWN_ALLOWED;
                    state_next   = S_FINISH;
                end
                else
                begin
                    ctl.idx_inc = 1'b1;
                    state_next  = S_A_RD;
                end
            end
            S_D_RD:
            begin
                if (st.deny_end)
                begin
                    // Neither table knows the MAC: busy, or a new request.
                    state_next = S_FINISH;
                    if (st.pending)
                    begin
                        outcome_next = OUT_BUSY;
                    end
                    else
                    begin
                        ctl.set_pending = 1'b1;
                        outcome_next    = OUT_NEW_REQUEST;
                    end
                end
                else
                begin
                    ctl.rd_deny = 1'b1;
                    state_next  = S_D_CMP;
                end
            end
            S_D_CMP:
            begin
                if (st.deny_hit)
                begin
                    outcome_next = OUT_KNOWN_DENIED;
                    state_next   = S_FINISH;
                end
                else
                begin
                    ctl.idx_inc = 1'b1;
                    state_next  = S_D_RD;
                end
            end
            S_FINISH:
            begin
                if (st.out_free)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/maf_datapath.sv
// Datapath of the MAC admission filter: captured word, header checks,
// allow and deny memories with counts, pending request and result register.
// Depends on maf_pkg and maf_stream_if.
`timescale 1ns / 1ps
`default_nettype none

module maf_datapath #(
    parameter int ALLOW_DEPTH = maf_pkg::DEFAULT_ALLOW_DEPTH,
    parameter int DENY_DEPTH  = maf_pkg::DEFAULT_DENY_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    maf_stream_if.sink          req,
    maf_stream_if.source        rsp,
    input  wire maf_pkg::ctrl_t ctl,
    output maf_pkg::stat_t      st
);
    import maf_pkg::*;

    localparam int AWA = (ALLOW_DEPTH > 1) ? $clog2(ALLOW_DEPTH) : 1;
    localparam int AWD = (DENY_DEPTH > 1) ? $clog2(DENY_DEPTH) : 1;
    localparam int CWA = $clog2(ALLOW_DEPTH + 1);
    localparam int CWD = $clog2(DENY_DEPTH + 1);
    localparam int IW  = (CWA > CWD) ? CWA : CWD;

    in_item_t    item_reg;
    out_item_t   out_data_reg;
    logic        out_valid_reg;
    logic [CWA-1:0] allow_count_reg;
    logic [CWD-1:0] deny_count_reg;
    logic [IW-1:0]  idx_reg;
    logic        pending_valid_reg;
    logic [47:0] pending_mac_reg;
    logic [47:0] allow_rd_reg;
    logic [47:0] deny_rd_reg;

    logic [47:0] allow_mem [ALLOW_DEPTH];
    logic [47:0] deny_mem  [DENY_DEPTH];

    logic        pkt_ok;
    logic        is_new_req;
    out_item_t   out_next;

    assign req.ready = ctl.take;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    assign pkt_ok = (item_reg.link_protocol == ETHERTYPE_IPV4)
                 && (item_reg.mac_length == MAC_BYTES)
                 && (item_reg.payload_bytes >= MIN_PAYLOAD)
                 && (item_reg.version_and_ihl[7:4] == IP_VERSION)
                 && (item_reg.version_and_ihl[3:0] == IP_IHL)
                 && (item_reg.fragment_word[12:0] == FRAG_NONE)
                 && (item_reg.ip_protocol == PROTO_TCP)
                 && item_reg.syn_flag;

    always_comb
    begin
        st            = '0;
        st.in_valid   = req.valid;
        st.cmd        = item_reg.cmd;
        st.pkt_ok     = pkt_ok;
        st.pending    = pending_valid_reg;
        st.allow_full = (allow_count_reg == CWA'(ALLOW_DEPTH));
        st.deny_full  = (deny_count_reg == CWD'(DENY_DEPTH));
        st.allow_end  = (idx_reg >= IW'(allow_count_reg));
        st.deny_end   = (idx_reg >= IW'(deny_count_reg));
        st.allow_hit  = (allow_rd_reg == item_reg.source_mac);
        st.deny_hit   = (deny_rd_reg == item_reg.source_mac);
        st.out_free   = !out_valid_reg || rsp.ready;
    end

    // Request identity is reported only with a new request, zero otherwise.
    assign is_new_req = (ctl.outcome == OUT_NEW_REQUEST);

    always_comb
    begin
        out_next.tag_out      = (item_reg.cmd == CMD_PACKET) ? item_reg.packet_tag : '0;
        out_next.verdict      = (ctl.outcome == OUT_KNOWN_ALLOWED);
        out_next.outcome      = ctl.outcome;
        out_next.request_mac  = is_new_req ? item_reg.source_mac : '0;
        out_next.request_ip   = is_new_req ? item_reg.source_ip : '0;
        out_next.request_port = is_new_req ? item_reg.target_port : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg     <= 1'b0;
            allow_count_reg   <= '0;
            deny_count_reg    <= '0;
            pending_valid_reg <= 1'b0;
            idx_reg           <= '0;
        end
        else
        begin
            if (ctl.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (ctl.wr_allow)
            begin
                allow_count_reg <= allow_count_reg + CWA'(1);
            end
            if (ctl.wr_deny)
            begin
                deny_count_reg <= deny_count_reg + CWD'(1);
            end

            if (ctl.set_pending)
            begin
                pending_valid_reg <= 1'b1;
            end
            else if (ctl.clear_pending)
            begin
                pending_valid_reg <= 1'b0;
            end

            if (ctl.idx_clear)
            begin
                idx_reg <= '0;
            end
            else if (ctl.idx_inc)
            begin
                idx_reg <= idx_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            item_reg <= req.data;
        end
        if (ctl.load_out)
        begin
            out_data_reg <= out_next;
        end
        if (ctl.set_pending)
        begin
            pending_mac_reg <= item_reg.source_mac;
        end
    end

    // Allow table: written at the fill position, read at the scan index.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_allow)
        begin
            allow_mem[allow_count_reg[AWA-1:0]] <= pending_mac_reg;
        end
        if (ctl.rd_allow)
        begin
            allow_rd_reg <= allow_mem[idx_reg[AWA-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_deny)
        begin
            deny_mem[deny_count_reg[AWD-1:0]] <= pending_mac_reg;
        end
        if (ctl.rd_deny)
        begin
            deny_rd_reg <= deny_mem[idx_reg[AWD-1:0]];
        end
    end

endmodule

`default_nettype wire
